// File: src/cbac_pkg.sv
// Package for the contiguous block allocator with compaction.
// Holds the table sizes, the command and result item types and the controller states.
// No dependencies.
package cbac_pkg;

  // Table geometry.
  localparam int unsigned SLOTS   = 32;
  localparam int unsigned ID_BITS = 8;
  localparam int unsigned ID_W    = ID_BITS;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  // Fixed field widths of the items.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned START_W = 5;
  localparam int unsigned LEN_W   = 6;

  // Width wide enough for start + length and for the slot count.
  localparam int unsigned SUM_W   = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_COMPACT = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SWEEP,
    ST_CLEAR,
    ST_READ,
    ST_RESP
  } state_e;

  // One command item.
  typedef struct packed {
    opcode_e              opcode;
    logic [OWNER_W-1:0]   owner_id;
    logic [START_W-1:0]   start_slot;
    logic [LEN_W-1:0]     run_length;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic                 status;
    logic [OWNER_W-1:0]   slot_owner;
  } rsp_t;

endpackage

// File: src/contiguous_block_allocator_compactor.sv
// Contiguous slot allocator with compaction: controller and slot table memory.
// Depends on cbac_pkg for sizes, item types, opcodes and states.
//
// Usage: commands arrive on the in_* channel (valid/stall) and each gives exactly one
// result item on the out_* channel (valid/stall). An item is taken at a clock edge where
// valid is high and stall is low.
// The slot table sits in one synchronous memory with a registered read; a valid bit per
// slot makes every slot read as free straight after reset, so no clearing pass is needed.
// Work per command, from acceptance to result in the output register:
//   insert: one write per cycle, one per slot of the run (none when rejected or empty);
//   read: one memory read;
//   delete: a read-modify-write sweep over every slot;
//   compact: the same sweep plus a clear step (ST_CLEAR) that frees the tail.
// The memory port pair (one read, one write per cycle) sets the sweep length.
// One command is worked at a time; in_stall_o is high while a command is in progress.
// The result is held in an output register, so a new command is accepted while the
// previous result still waits. If the receiver stalls and that register is full, the
// next result waits in the controller until the register frees.
// Reset (rst_ni low) empties the table and drops any command or result in flight.
module contiguous_block_allocator_compactor
  import cbac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  // Controller registers.
  state_e              state_q, state_d;
  opcode_e             op_q, op_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    end_q, end_d;
  logic [CNT_W-1:0]    wptr_q, wptr_d;
  logic                rdok_q, rdok_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q;
  logic                out_valid_q;

  // Memory and valid bits.
  logic [ID_W-1:0]     mem [SLOTS];
  logic [SLOTS-1:0]    valid_q;
  logic [ID_W-1:0]     rd_data_q;
  logic                rd_vld_q;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [ID_W-1:0]     wr_data;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                clr_en;
  logic [SLOTS-1:0]    keep_mask;

  // Helpers.
  logic                in_accept;
  logic [SUM_W-1:0]    run_end;
  logic                run_ovf;
  logic                rd_in_range;
  logic [ID_W-1:0]     rd_owner;
  logic [SLOT_W-1:0]   proc_addr;
  logic                out_load;

  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Range checks on the incoming command.
  assign run_end     = SUM_W'(in_data_i.start_slot) + SUM_W'(in_data_i.run_length);
  assign run_ovf     = run_end > SUM_W'(SLOTS);
  assign rd_in_range = SUM_W'(in_data_i.start_slot) < SUM_W'(SLOTS);

  // A slot that has not been written since reset reads as free.
  assign rd_owner  = rd_vld_q ? rd_data_q : '0;
  assign proc_addr = SLOT_W'(cnt_q - CNT_W'(1));

  // Slots at or beyond the compaction write pointer are freed after the sweep.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      keep_mask[i] = CNT_W'(i) < wptr_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (run_ovf || (in_data_i.run_length == '0)) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_INSERT;
              end
            end
            OP_DELETE:  state_d = ST_SWEEP;
            OP_COMPACT: state_d = ST_SWEEP;
            OP_READ:    state_d = ST_READ;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_INSERT: begin
        if ((cnt_q + CNT_W'(1)) == end_q) begin
          state_d = ST_RESP;
        end
      end
      ST_SWEEP: begin
        if (cnt_q == CNT_W'(SLOTS)) begin
          state_d = (op_q == OP_COMPACT) ? ST_CLEAR : ST_RESP;
        end
      end
      ST_CLEAR: state_d = ST_RESP;
      ST_READ:  state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates per state.
  always_comb begin
    op_d     = op_q;
    id_d     = id_q;
    cnt_d    = cnt_q;
    end_d    = end_q;
    wptr_d   = wptr_q;
    rdok_d   = rdok_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_addr  = cnt_q[SLOT_W-1:0];
    wr_data  = id_q;
    rd_en    = 1'b0;
    rd_addr  = cnt_q[SLOT_W-1:0];
    clr_en   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d   = in_data_i.opcode;
          id_d   = ID_W'(in_data_i.owner_id);
          end_d  = CNT_W'(run_end);
          wptr_d = '0;
          rdok_d = rd_in_range;
          res_d.status     = (in_data_i.opcode == OP_INSERT) && run_ovf;
          res_d.slot_owner = '0;
          if (in_data_i.opcode == OP_INSERT) begin
            cnt_d = CNT_W'(in_data_i.start_slot);
          end else begin
            cnt_d = '0;
          end
          rd_en   = (in_data_i.opcode == OP_READ);
          rd_addr = SLOT_W'(in_data_i.start_slot);
        end
      end
      ST_INSERT: begin
        // One slot of the run per cycle.
        wr_en   = 1'b1;
        wr_addr = cnt_q[SLOT_W-1:0];
        wr_data = id_q;
        cnt_d   = cnt_q + CNT_W'(1);
      end
      ST_SWEEP: begin
        // Read slot cnt while the slot read last cycle is processed.
        if (cnt_q < CNT_W'(SLOTS)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_q[SLOT_W-1:0];
        end
        if (cnt_q != '0) begin
          if (op_q == OP_DELETE) begin
            if (rd_owner == id_q) begin
              wr_en   = 1'b1;
              wr_addr = proc_addr;
              wr_data = '0;
            end
          end else if (rd_owner != '0) begin
            // The write pointer never passes the slot being read.
            wr_en   = 1'b1;
            wr_addr = wptr_q[SLOT_W-1:0];
            wr_data = rd_owner;
            wptr_d  = wptr_q + CNT_W'(1);
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_CLEAR: begin
        clr_en = 1'b1;
      end
      ST_READ: begin
        res_d.slot_owner = rdok_q ? OWNER_W'(rd_owner) : '0;
      end
      ST_RESP: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command and work registers.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    cnt_q  <= cnt_d;
    end_q  <= end_d;
    wptr_q <= wptr_d;
    rdok_q <= rdok_d;
    res_q  <= res_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Slot table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Per-slot valid bits; reset frees every slot at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_en) begin
        valid_q <= valid_q & keep_mask;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
    end
  end

endmodule
